>>> design/scanline_polygon_span_fill_macros.svh
`ifndef SCANLINE_POLYGON_SPAN_FILL_MACROS_SVH
`define SCANLINE_POLYGON_SPAN_FILL_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SPF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spf assertion failed");

// next-cycle implication
`define SPF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spf assertion failed");

`endif

>>> design/spf_pkg.sv
package spf_pkg;

	localparam int MAX_VERTICES  = 16;
	localparam int MAX_CROSSINGS = 12;
	localparam int COORD_BITS    = 12;

	localparam int VA       = $clog2(MAX_VERTICES);
	localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);
	localparam int HB       = $clog2(MAX_CROSSINGS + 1);
	localparam int DW       = COORD_BITS + 1;
	localparam int PW       = 2 * DW;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_SCAN  = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic        mode;
		logic [3:0]  vertex_index;
		coord_t      vertex_x;
		coord_t      vertex_y;
		logic [4:0]  vertex_count;
		coord_t      row_y;
	} req_t;

	typedef struct packed {
		coord_t span_row;
		coord_t span_x_start;
		coord_t span_x_end;
		logic   span_valid;
		logic   last_span;
	} rsp_t;

	// classified item handed from front to back
	typedef struct packed {
		logic                scan;
		logic                wr_en;
		logic [VA-1:0]       slot;
		coord_t              x;
		coord_t              y;
		logic [CNT_BITS-1:0] n;
		coord_t              row;
	} job_t;

endpackage

>>> design/spf_ram.sv
module spf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/spf_front.sv
module spf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spf_pkg::req_t req,
	output logic          job_valid,
	output spf_pkg::job_t job,
	input  logic          pop
);

	spf_pkg::job_t cls;
	spf_pkg::job_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          push;

	always_comb begin
		cls.scan  = (req.mode == spf_pkg::MODE_SCAN);
		cls.wr_en = (32'(req.vertex_index) < spf_pkg::MAX_VERTICES);
		cls.slot  = spf_pkg::VA'(req.vertex_index);
		cls.x     = req.vertex_x;
		cls.y     = req.vertex_y;
		cls.row   = req.row_y;
		if (32'(req.vertex_count) > spf_pkg::MAX_VERTICES) begin
			cls.n = spf_pkg::CNT_BITS'(spf_pkg::MAX_VERTICES);
		end else begin
			cls.n = spf_pkg::CNT_BITS'(req.vertex_count);
		end
	end

	assign req_stall = (fill_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign job_valid = (fill_q != 2'd0);
	assign job       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && job_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop && job_valid);
		end
	end

endmodule

>>> design/spf_div.sv
module spf_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [spf_pkg::PW-1:0]  num,
	input  logic signed [spf_pkg::DW-1:0]  den,
	output logic                           done,
	output logic signed [spf_pkg::PW-1:0]  quo
);

	localparam int SB = $clog2(spf_pkg::PW + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [SB-1:0]          step_q;
	logic [spf_pkg::PW-1:0] acc_q;
	logic [spf_pkg::DW-1:0] rem_q;
	logic [spf_pkg::DW-1:0] dmag_q;
	logic                   neg_q;
	logic [spf_pkg::DW:0]   trial;
	logic [spf_pkg::DW:0]   diff;
	logic                   fits;

	assign trial = {rem_q, acc_q[spf_pkg::PW-1]};
	assign diff  = trial - {1'b0, dmag_q};
	assign fits  = (trial >= {1'b0, dmag_q});
	assign done  = done_q;
	assign quo   = neg_q ? -$signed(acc_q) : $signed(acc_q);

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= num[spf_pkg::PW-1] ? -num : num;
			dmag_q <= den[spf_pkg::DW-1] ? -den : den;
			neg_q  <= num[spf_pkg::PW-1] ^ den[spf_pkg::DW-1];
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[spf_pkg::DW-1:0] : trial[spf_pkg::DW-1:0];
			acc_q <= {acc_q[spf_pkg::PW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SB'(spf_pkg::PW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == SB'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> design/spf_back.sv
module spf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  spf_pkg::job_t job,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spf_pkg::rsp_t rsp
);

	localparam int C = spf_pkg::COORD_BITS;
	localparam int M = spf_pkg::MAX_CROSSINGS;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FIRST = 5'b00010,
		S_EDGE  = 5'b00100,
		S_DIV   = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t                       state_q;
	spf_pkg::coord_t              row_q;
	logic [spf_pkg::CNT_BITS-1:0] n_q;
	logic [spf_pkg::VA-1:0]       idx_q;
	logic                         closing_q;
	spf_pkg::coord_t              v0x_q, v0y_q, px_q, py_q;
	logic [spf_pkg::HB-1:0]       cnt_q;
	spf_pkg::coord_t              hits_q [M];
	spf_pkg::coord_t              ins [M];
	logic [M-1:0]                 lt;
	logic                         out_valid_q;
	spf_pkg::rsp_t                out_q;

	logic                         ram_we, ram_re;
	logic [spf_pkg::VA-1:0]       ram_raddr;
	logic [2*C-1:0]               ram_rdata;
	spf_pkg::coord_t              cur_x, cur_y, hit_new;
	logic                         straddle, take, adv, last_vtx, out_free, emit;
	logic signed [spf_pkg::DW-1:0] dx, dr, den;
	logic signed [spf_pkg::PW-1:0] prod, quo;
	logic                         div_done;

	spf_ram #(.WIDTH(2 * C), .DEPTH(spf_pkg::MAX_VERTICES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (job.slot),
		.wdata ({job.x, job.y}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	spf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (take),
		.num    (prod),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	// closing edge runs from the last vertex back to vertex 0
	assign cur_x = closing_q ? v0x_q : ram_rdata[2*C-1:C];
	assign cur_y = closing_q ? v0y_q : ram_rdata[C-1:0];

	assign dx    = {cur_x[C-1], cur_x} - {px_q[C-1], px_q};
	assign dr    = {row_q[C-1], row_q} - {py_q[C-1], py_q};
	assign den   = {cur_y[C-1], cur_y} - {py_q[C-1], py_q};
	assign prod  = dx * dr;
	assign straddle = (($signed(row_q) >= $signed(py_q)) != ($signed(row_q) >= $signed(cur_y)))
		&& (py_q != cur_y);
	assign take  = (state_q == S_EDGE) && straddle && (cnt_q < spf_pkg::HB'(M));
	assign adv   = ((state_q == S_EDGE) && !take) || ((state_q == S_DIV) && div_done);
	assign last_vtx = ((spf_pkg::CNT_BITS'(idx_q) + 1'b1) == n_q);
	// crossing lies between the edge endpoints, so the low bits are exact
	assign hit_new = px_q + quo[C-1:0];

	assign pop    = (state_q == S_IDLE) && job_valid;
	assign ram_we = pop && !job.scan && job.wr_en;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q + 1'b1;
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = '0;
				ram_re    = pop && job.scan && (job.n >= spf_pkg::CNT_BITS'(2));
			end
			S_FIRST: begin
				ram_raddr = idx_q;
				ram_re    = 1'b1;
			end
			S_EDGE, S_DIV: begin
				ram_re = adv && !closing_q && !last_vtx;
			end
			S_EMIT: begin
				ram_re = 1'b0;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// sorted insert: every slot decides on its own from its neighbor
	always_comb begin
		for (int k = 0; k < M; k++) begin
			lt[k] = (spf_pkg::HB'(k) < cnt_q) && ($signed(hits_q[k]) <= $signed(hit_new));
		end
		for (int k = 0; k < M; k++) begin
			if (lt[k]) begin
				ins[k] = hits_q[k];
			end else if (k == 0) begin
				ins[k] = hit_new;
			end else if (lt[k-1]) begin
				ins[k] = hit_new;
			end else begin
				ins[k] = hits_q[k-1];
			end
		end
	end

	assign out_free = !out_valid_q || !rsp_stall;
	assign emit     = (state_q == S_EMIT) && out_free;

	always_ff @(posedge clk) begin
		if (pop) begin
			row_q <= job.row;
			n_q   <= job.n;
		end
		if (state_q == S_FIRST) begin
			v0x_q <= ram_rdata[2*C-1:C];
			v0y_q <= ram_rdata[C-1:0];
			px_q  <= ram_rdata[2*C-1:C];
			py_q  <= ram_rdata[C-1:0];
		end else if (adv) begin
			px_q <= cur_x;
			py_q <= cur_y;
		end
		if ((state_q == S_DIV) && div_done) begin
			hits_q <= ins;
		end else if (emit) begin
			for (int k = 0; k < M - 2; k++) begin
				hits_q[k] <= hits_q[k+2];
			end
		end
		if (emit) begin
			out_q.span_row <= row_q;
			if (cnt_q < spf_pkg::HB'(2)) begin
				out_q.span_x_start <= '0;
				out_q.span_x_end   <= '0;
				out_q.span_valid   <= 1'b0;
				out_q.last_span    <= 1'b1;
			end else begin
				out_q.span_x_start <= hits_q[0];
				out_q.span_x_end   <= hits_q[1];
				out_q.span_valid   <= 1'b1;
				out_q.last_span    <= (cnt_q < spf_pkg::HB'(4));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			closing_q   <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop && job.scan) begin
						cnt_q     <= '0;
						closing_q <= 1'b0;
						idx_q     <= spf_pkg::VA'(1);
						if (job.n < spf_pkg::CNT_BITS'(2)) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_FIRST;
						end
					end
				end
				S_FIRST: begin
					state_q <= S_EDGE;
				end
				S_EDGE, S_DIV: begin
					if (take) begin
						state_q <= S_DIV;
					end else if (adv) begin
						if (state_q == S_DIV) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (closing_q) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_EDGE;
							if (last_vtx) begin
								closing_q <= 1'b1;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
					end
				end
				S_EMIT: begin
					if (emit) begin
						if (cnt_q < spf_pkg::HB'(4)) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q - spf_pkg::HB'(2);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

>>> design/scanline_polygon_span_fill.sv
// channel  direction  word    handshake
// req      in         req_t   req_valid / req_stall
// rsp      out        rsp_t   rsp_valid / rsp_stall
//
// Vertex write: the back end writes the vertex RAM as it pops the word from the two-word queue.
// Scan of n vertices: the serial divider (one quotient bit per cycle, 26 bits)
// dominates, one run per stored crossing, up to 12 stored crossings per row.
// Reset clears queue pointers, sequencer and output valid flag; vertex RAM is not cleared.
// req_stall rises only when the queue is full; a stalled rsp holds the back end
// in its emit state while the front keeps taking words until its queue is full.
module scanline_polygon_span_fill (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spf_pkg::rsp_t rsp
);

	logic          job_valid;
	logic          pop;
	spf_pkg::job_t job;

	spf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.job_valid (job_valid),
		.job       (job),
		.pop       (pop)
	);

	spf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

>>> design/spf_checker.sv
module spf_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input spf_pkg::rsp_t rsp
);

`include "scanline_polygon_span_fill_macros.svh"

	`SPF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`SPF_ASSERT_NOW(a_empty_is_last, rsp_valid && !rsp.span_valid, rsp.last_span)
	`SPF_ASSERT_NOW(a_empty_zero, rsp_valid && !rsp.span_valid, {rsp.span_x_start, rsp.span_x_end} == '0)
	`SPF_ASSERT_NOW(a_span_order, rsp_valid && rsp.span_valid, $signed(rsp.span_x_start) <= $signed(rsp.span_x_end))

endmodule

bind scanline_polygon_span_fill spf_checker u_spf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
